FILE: hdl/rwl_pkg.sv
// Package with the shared types, codes and sizes of the readers-writer lock arbiter.
package rwl_pkg;

  localparam int WAIT_DEPTH  = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_HOLDERS = 255;
  localparam int IDX_W       = $clog2(WAIT_DEPTH);
  localparam int CNT_W       = $clog2(WAIT_DEPTH + 1);
  localparam int HOLD_W      = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_RD_LOCK   = 2'd0,
    CMD_WR_LOCK   = 2'd1,
    CMD_RD_UNLOCK = 2'd2,
    CMD_WR_UNLOCK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_RELEASED     = 3'd2,
    ST_QUEUE_FULL   = 3'd3,
    ST_NOT_HELD     = 3'd4,
    ST_READER_LIMIT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    status_t                   status;
    logic signed [HOLD_W-1:0]  hc;
    logic                      own;
    logic [ID_BITS-1:0]        id;
    logic                      kind;
    logic                      wake_w;
    logic [IDX_W-1:0]          w_idx;
    logic [CNT_W-1:0]          nrd;
    logic [IDX_W-1:0]          r_top;
  } job_t;

  typedef struct packed {
    logic               r_en;
    logic [IDX_W-1:0]   r_addr;
    logic               w_en;
    logic [IDX_W-1:0]   w_addr;
    logic [ID_BITS-1:0] id;
  } stack_wr_t;

  typedef struct packed {
    logic             r_en;
    logic [IDX_W-1:0] r_addr;
    logic             w_en;
    logic [IDX_W-1:0] w_addr;
  } stack_rd_t;

endpackage

FILE: hdl/readers_writer_lock_arbiter_top.sv
// Top level of the writer-preferred readers-writer lock arbiter.
//
// Commands arrive on the input channel (in_valid, in_stall, command, requester_id);
// a beat is taken when in_valid is high and in_stall is low. Each command yields
// one or more result beats on the output channel (out_valid, out_stall and the
// grant fields), the final one marked by last. The front end updates the holder
// count and the two waiting stacks in the cycle it takes a beat and hands a job
// to a four-entry queue; the back end turns jobs into result beats.
// A command that wakes nobody gives its single result from its queue slot through
// the back end's result registers; the back end takes no new job until that result is taken.
// A command that wakes waiters gives one result per woken id, each one paced by
// the registered read of the stack memory; the input stalls until the last of those
// results is taken, so no push can overwrite a pending id.
// When out_stall is high the current result holds; the queue keeps taking
// commands until it fills. Reset empties the queue and both stacks and leaves
// the resource unlocked; no clearing pass is needed.
module readers_writer_lock_arbiter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [7:0]                   requester_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         grant_valid,
  output logic [7:0]                   granted_id,
  output logic                         grant_kind,
  output logic [2:0]                   status,
  output logic signed [8:0]            holder_count,
  output logic                         last
);
  import rwl_pkg::*;

  job_t               push_job, head_job;
  logic               q_push, q_pop, q_full, q_empty;
  stack_wr_t          stack_wr;
  stack_rd_t          stack_rd;
  logic [ID_BITS-1:0] r_data, w_data;
  logic               wake_done;

  rwl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .requester_id (requester_id),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job),
    .stack_wr     (stack_wr),
    .wake_done    (wake_done)
  );

  rwl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  rwl_ram #(.WIDTH(ID_BITS), .DEPTH(WAIT_DEPTH)) u_reader_stack (
    .clk     (clk),
    .wr_en   (stack_wr.r_en),
    .wr_addr (stack_wr.r_addr),
    .wr_data (stack_wr.id),
    .rd_en   (stack_rd.r_en),
    .rd_addr (stack_rd.r_addr),
    .rd_data (r_data)
  );

  rwl_ram #(.WIDTH(ID_BITS), .DEPTH(WAIT_DEPTH)) u_writer_stack (
    .clk     (clk),
    .wr_en   (stack_wr.w_en),
    .wr_addr (stack_wr.w_addr),
    .wr_data (stack_wr.id),
    .rd_en   (stack_rd.w_en),
    .rd_addr (stack_rd.w_addr),
    .rd_data (w_data)
  );

  rwl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .stack_rd     (stack_rd),
    .r_data       (r_data),
    .w_data       (w_data),
    .wake_done    (wake_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grant_valid  (grant_valid),
    .granted_id   (granted_id),
    .grant_kind   (grant_kind),
    .status       (status),
    .holder_count (holder_count),
    .last         (last)
  );

endmodule

FILE: hdl/rwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/rwl_front.sv
// Front end: accepts commands, updates the lock counts and issues jobs to the queue.
module rwl_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                command,
  input  logic [rwl_pkg::ID_BITS-1:0] requester_id,
  input  logic                      q_full,
  output logic                      q_push,
  output rwl_pkg::job_t             q_job,
  output rwl_pkg::stack_wr_t        stack_wr,
  input  logic                      wake_done
);
  import rwl_pkg::*;

  localparam logic signed [HOLD_W:0] MAX_H = (HOLD_W + 1)'(MAX_HOLDERS);
  localparam logic [CNT_W-1:0]       FULL  = CNT_W'(WAIT_DEPTH);

  logic signed [HOLD_W-1:0] holders, h1, h2;
  logic [CNT_W-1:0]         ww, rw, ww1, rw1, ww2, rw2, nrd;
  logic                     pend;
  logic                     accept;
  logic                     own, kind, wake, push_r, push_w, wake_w;
  status_t                  st;
  logic signed [HOLD_W:0]   h_ext, room;

  assign in_stall = pend || q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    h1     = holders;
    ww1    = ww;
    rw1    = rw;
    st     = ST_GRANTED;
    own    = 1'b0;
    kind   = 1'b0;
    wake   = 1'b0;
    push_r = 1'b0;
    push_w = 1'b0;
    h_ext  = (HOLD_W + 1)'(holders);
    case (cmd_t'(command))
      CMD_RD_LOCK: begin
        if (ww == '0 && !holders[HOLD_W-1]) begin
          if (h_ext < MAX_H) begin
            h1  = holders + HOLD_W'(1);
            own = 1'b1;
          end else begin
            st = ST_READER_LIMIT;
          end
        end else if (rw == FULL) begin
          st = ST_QUEUE_FULL;
        end else begin
          push_r = 1'b1;
          rw1    = rw + CNT_W'(1);
          st     = ST_QUEUED;
          wake   = 1'b1;
        end
      end
      CMD_WR_LOCK: begin
        if (holders == '0) begin
          h1   = -HOLD_W'(1);
          own  = 1'b1;
          kind = 1'b1;
        end else if (ww == FULL) begin
          st = ST_QUEUE_FULL;
        end else begin
          push_w = 1'b1;
          ww1    = ww + CNT_W'(1);
          st     = ST_QUEUED;
          wake   = 1'b1;
        end
      end
      CMD_RD_UNLOCK: begin
        if (holders <= HOLD_W'(0)) begin
          st = ST_NOT_HELD;
        end else begin
          h1   = holders - HOLD_W'(1);
          st   = ST_RELEASED;
          wake = (holders == HOLD_W'(1));
        end
      end
      default: begin
        if (holders != -HOLD_W'(1)) begin
          st = ST_NOT_HELD;
        end else begin
          h1   = '0;
          st   = ST_RELEASED;
          wake = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    h2     = h1;
    ww2    = ww1;
    rw2    = rw1;
    wake_w = 1'b0;
    nrd    = '0;
    room   = MAX_H - (HOLD_W + 1)'(h1);
    if (wake && h1 != -HOLD_W'(1)) begin
      if (ww1 != '0) begin
        if (h1 == '0) begin
          wake_w = 1'b1;
          ww2    = ww1 - CNT_W'(1);
          h2     = -HOLD_W'(1);
        end
      end else begin
        if ((HOLD_W + 1)'(rw1) < room) begin
          nrd = rw1;
        end else begin
          nrd = room[CNT_W-1:0];
        end
        rw2 = rw1 - nrd;
        h2  = h1 + HOLD_W'(nrd);
      end
    end
  end

  always_comb begin
    q_push       = accept;
    q_job.status = st;
    q_job.hc     = h2;
    q_job.own    = own;
    q_job.id     = requester_id;
    q_job.kind   = kind;
    q_job.wake_w = wake_w;
    q_job.w_idx  = ww2[IDX_W-1:0];
    q_job.nrd    = nrd;
    q_job.r_top  = IDX_W'(rw1 - CNT_W'(1));
    stack_wr.r_en   = accept && push_r;
    stack_wr.r_addr = rw[IDX_W-1:0];
    stack_wr.w_en   = accept && push_w;
    stack_wr.w_addr = ww[IDX_W-1:0];
    stack_wr.id     = requester_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holders <= '0;
      ww      <= '0;
      rw      <= '0;
      pend    <= 1'b0;
    end else begin
      if (accept) begin
        holders <= h2;
        ww      <= ww2;
        rw      <= rw2;
        pend    <= wake_w || (nrd != '0);
      end else if (wake_done) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/rwl_queue.sv
// Short job queue between the front end and the back end.
module rwl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rwl_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output rwl_pkg::job_t head,
  output logic          empty
);
  import rwl_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: hdl/rwl_back.sv
// Back end: turns each job into result beats, reading woken ids from the stacks.
module rwl_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  rwl_pkg::job_t                  q_job,
  output logic                           q_pop,
  output rwl_pkg::stack_rd_t             stack_rd,
  input  logic [rwl_pkg::ID_BITS-1:0]    r_data,
  input  logic [rwl_pkg::ID_BITS-1:0]    w_data,
  output logic                           wake_done,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           grant_valid,
  output logic [rwl_pkg::ID_BITS-1:0]    granted_id,
  output logic                           grant_kind,
  output logic [2:0]                     status,
  output logic signed [rwl_pkg::HOLD_W-1:0] holder_count,
  output logic                           last
);
  import rwl_pkg::*;

  back_state_t      state, state_next;
  job_t             job;
  logic [CNT_W-1:0] remain;
  logic [IDX_W-1:0] r_addr;
  logic             first;
  logic             from_w;
  logic             has_read;
  logic             q_read;
  logic             emit_done;

  assign q_read    = q_job.wake_w || (q_job.nrd != '0);
  assign emit_done = (state == B_EMIT) && !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = q_read ? B_READ : B_EMIT;
        end
      end
      B_READ: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!out_stall) begin
          state_next = (remain != '0) ? B_READ : B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop           = (state == B_IDLE) && !q_empty;
    stack_rd.r_en   = 1'b0;
    stack_rd.r_addr = r_addr;
    stack_rd.w_en   = 1'b0;
    stack_rd.w_addr = q_job.w_idx;
    out_valid       = (state == B_EMIT);
    wake_done       = emit_done && (remain == '0) && has_read;
    if (q_pop) begin
      stack_rd.w_en   = q_job.wake_w;
      stack_rd.r_en   = !q_job.wake_w && (q_job.nrd != '0);
      stack_rd.r_addr = q_job.r_top;
    end else if (emit_done && remain != '0) begin
      stack_rd.r_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job      <= q_job;
      first    <= 1'b1;
      from_w   <= q_job.wake_w;
      has_read <= q_read;
      r_addr   <= q_job.r_top - IDX_W'(1);
      remain   <= (!q_job.wake_w && q_job.nrd != '0) ? q_job.nrd - CNT_W'(1) : '0;
      if (!q_read) begin
        grant_valid  <= q_job.own;
        granted_id   <= q_job.own ? q_job.id : '0;
        grant_kind   <= q_job.own ? q_job.kind : 1'b0;
        status       <= q_job.status;
        holder_count <= q_job.hc;
        last         <= 1'b1;
      end
    end else if (state == B_READ) begin
      first        <= 1'b0;
      grant_valid  <= 1'b1;
      granted_id   <= from_w ? w_data : r_data;
      grant_kind   <= from_w;
      status       <= first ? job.status : ST_GRANTED;
      holder_count <= job.hc;
      last         <= (remain == '0);
    end else if (emit_done && remain != '0) begin
      remain <= remain - CNT_W'(1);
      r_addr <= r_addr - IDX_W'(1);
    end
  end

endmodule

FILE: hdl/rwl_checker.sv
// Port-level checker for the readers-writer lock arbiter and its bind statement.
module rwl_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        command,
  input logic [7:0]        requester_id,
  input logic              out_valid,
  input logic              out_stall,
  input logic              grant_valid,
  input logic [7:0]        granted_id,
  input logic              grant_kind,
  input logic [2:0]        status,
  input logic signed [8:0] holder_count,
  input logic              last
);
  import rwl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(granted_id) && $stable(last))
    else $error("A stalled result beat changed.");

  a_writer_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && grant_valid && grant_kind |-> holder_count == -9'sd1 && last)
    else $error("A writer grant did not leave the writer as sole holder.");

  a_no_grant_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !grant_valid |-> last && granted_id == '0 && !grant_kind)
    else $error("A result without a grant was not a single final beat.");

  a_queued_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_QUEUE_FULL || status == ST_NOT_HELD ||
                  status == ST_READER_LIMIT) |-> !grant_valid)
    else $error("A rejected command produced a grant.");

endmodule

bind readers_writer_lock_arbiter_top rwl_checker u_rwl_checker (.*);
